// ===== rtl/core/ramp_soak_setpoint_profile_core_assert.svh =====
// Assertion macros for the ramp/soak setpoint profile core.
// Included by the checker; no other dependencies.
`ifndef RAMP_SOAK_SETPOINT_PROFILE_CORE_ASSERT_SVH
`define RAMP_SOAK_SETPOINT_PROFILE_CORE_ASSERT_SVH

// clocked assertion, disabled during reset
`define RSP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rsp assertion failed");

// clocked assertion, also checked during reset
`define RSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rsp assertion failed");

`endif

// ===== rtl/core/rsp_pkg.sv =====
// Shared constants, types and command codes of the setpoint profile core.
// No dependencies.
package rsp_pkg;

  localparam int MAX_STEPS  = 16;
  localparam int IDX_W      = $clog2(MAX_STEPS);
  localparam int CNT_W      = $clog2(MAX_STEPS + 1);
  localparam int TEMP_W     = 16;
  localparam int DUR_W      = 24;
  localparam int EL_W       = 32;
  localparam int SUM_W      = DUR_W + CNT_W;
  localparam int DIV_W      = 40;
  localparam int DIVC_W     = 6;
  localparam int REM_W      = 29;
  localparam int IDX_OUT_W  = 4;
  localparam int IN_W       = 96;
  localparam int OUT_W      = 80;

  // days = floor(floor(e / 128) / 675), the second step by reciprocal multiply
  localparam int DAY_PRE_SHIFT = 7;
  localparam int DAY_IN_W      = EL_W - DAY_PRE_SHIFT;
  localparam int DAY_MUL_W     = 26;
  localparam int DAY_PROD_W    = DAY_IN_W + DAY_MUL_W;
  localparam int DAY_SHIFT     = 35;
  localparam int DAYS_W        = 16;

  localparam logic [DAY_MUL_W-1:0] DAY_RECIP = DAY_MUL_W'(50903317);
  localparam logic [REM_W-1:0]  REM_MAX     = REM_W'(268435455);
  localparam logic [DIVC_W-1:0] DIV_LAST    = DIVC_W'(DIV_W - 1);
  localparam logic signed [TEMP_W-1:0] DEFAULT_SP_RESET = TEMP_W'(2000);

  localparam logic [2:0] CMD_QUERY  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_START  = 3'd3;
  localparam logic [2:0] CMD_STOP   = 3'd4;

  typedef struct packed {
    logic                     ramp;
    logic signed [TEMP_W-1:0] t_start;
    logic signed [TEMP_W-1:0] t_end;
    logic [DUR_W-1:0]         dur;
  } step_t;

  typedef struct packed {
    logic capture;
    logic prime;
    logic walk;
    logic mul;
    logic div_step;
    logic load_out;
  } rsp_cmd_t;

  typedef struct packed {
    logic walk_go;
    logic walk_last;
  } rsp_sts_t;

endpackage

// ===== rtl/core/rsp_datapath.sv =====
// Datapath: step table, profile state, step walk, multiply and serial divide lanes.
// Depends on rsp_pkg; driven by rsp_ctrl.
module rsp_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsp_pkg::rsp_cmd_t cmd_i,
  output rsp_pkg::rsp_sts_t sts_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i,
  input  logic [2:0]        in_cmd_i,
  input  logic [95:0]       in_data_i,
  output logic [79:0]       out_data_o
);
  import rsp_pkg::*;

  step_t                    tbl [MAX_STEPS];
  step_t                    rd_q, new_step;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     active_q, active_d;
  logic signed [TEMP_W-1:0] dflt_q;
  logic [EL_W-1:0]          e_q;
  logic                     tv_q, acc_q;
  logic [CNT_W-1:0]         widx_q, widx_n;
  logic [SUM_W-1:0]         raw_q, adj_q, raw_n, adj_n;
  logic [DUR_W-1:0]         dadj_c, dadj_q, off_q;
  logic                     idx_found_q, sp_found_q, sp_ramp_q, neg_q;
  logic [IDX_W-1:0]         idx_q;
  logic signed [TEMP_W-1:0] ts_q, last_te_q;
  logic signed [TEMP_W:0]   diff_q, diff_c;
  logic [TEMP_W-1:0]        absd;
  logic [EL_W-1:0]          off_full;
  logic [DIV_W-1:0]         na_q, nb_q;
  logic [DUR_W-1:0]         ra_q, rb_q;
  logic [DUR_W:0]           ta, tb;
  logic [DAYS_W-1:0]        days_q;
  logic [DAY_PROD_W-1:0]    days_prod;
  logic                     go;
  logic signed [TEMP_W:0]   q_s;
  logic signed [TEMP_W+1:0] sp_sum;
  logic signed [TEMP_W-1:0] sp_out;
  logic [IDX_OUT_W-1:0]     idx_out;
  logic [REM_W-1:0]         rem_out;
  logic [EL_W-1:0]          rem_full;
  logic [15:0]              days_out;
  logic [6:0]               prog_out;
  logic                     drives;
  logic [79:0]              out_q;

  assign new_step.ramp    = in_data_i[0];
  assign new_step.t_start = in_data_i[16:1];
  assign new_step.t_end   = in_data_i[32:17];
  assign new_step.dur     = in_data_i[56:33];

  always_comb begin
    count_d  = count_q;
    active_d = active_q;
    if (cmd_i.capture) begin
      case (in_cmd_i)
        CMD_APPEND: if (count_q != CNT_W'(MAX_STEPS)) count_d = count_q + CNT_W'(1);
        CMD_CLEAR:  count_d = '0;
        CMD_START:  active_d = 1'b1;
        CMD_STOP:   active_d = 1'b0;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      active_q <= 1'b0;
      dflt_q   <= DEFAULT_SP_RESET;
    end else begin
      count_q  <= count_d;
      active_q <= active_d;
      if (cfg_we_i) dflt_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && in_cmd_i == CMD_APPEND && count_q != CNT_W'(MAX_STEPS)) begin
      tbl[count_q[IDX_W-1:0]] <= new_step;
    end
    if (cmd_i.prime) begin
      rd_q <= tbl[0];
    end else if (cmd_i.walk) begin
      rd_q <= tbl[widx_n[IDX_W-1:0]];
    end
  end

  assign go     = active_q && (count_q != '0) && tv_q;
  assign widx_n = widx_q + CNT_W'(1);
  assign dadj_c = (rd_q.dur == '0) ? DUR_W'(1) : rd_q.dur;
  assign raw_n  = raw_q + SUM_W'(rd_q.dur);
  assign adj_n  = adj_q + SUM_W'(dadj_c);
  assign off_full = e_q - EL_W'(adj_q);
  assign diff_c = TEMP_W'(rd_q.t_end) - TEMP_W'(rd_q.t_start) == 0 ? '0 :
                  (TEMP_W+1)'(rd_q.t_end) - (TEMP_W+1)'(rd_q.t_start);
  assign absd   = diff_q[TEMP_W] ? TEMP_W'(-diff_q) : TEMP_W'(diff_q);

  assign days_prod = DAY_PROD_W'(e_q[EL_W-1:DAY_PRE_SHIFT]) * DAY_PROD_W'(DAY_RECIP);

  assign sts_o.walk_go   = go;
  assign sts_o.walk_last = (widx_q == count_q - CNT_W'(1));

  assign ta = {ra_q, na_q[DIV_W-1]};
  assign tb = {rb_q, nb_q[DIV_W-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      e_q   <= in_data_i[88:57];
      tv_q  <= in_data_i[89];
      acc_q <= !(in_cmd_i == CMD_APPEND && count_q == CNT_W'(MAX_STEPS));
    end
    if (cmd_i.prime) begin
      widx_q      <= '0;
      raw_q       <= '0;
      adj_q       <= '0;
      idx_found_q <= 1'b0;
      sp_found_q  <= 1'b0;
      sp_ramp_q   <= 1'b0;
      idx_q       <= IDX_W'(count_q - CNT_W'(1));
      dadj_q      <= DUR_W'(1);
      off_q       <= '0;
      diff_q      <= '0;
    end else if (cmd_i.walk) begin
      widx_q    <= widx_n;
      raw_q     <= raw_n;
      adj_q     <= adj_n;
      last_te_q <= rd_q.t_end;
      if (!idx_found_q && e_q < EL_W'(raw_n)) begin
        idx_found_q <= 1'b1;
        idx_q       <= widx_q[IDX_W-1:0];
      end
      if (!sp_found_q && e_q < EL_W'(adj_n)) begin
        sp_found_q <= 1'b1;
        sp_ramp_q  <= rd_q.ramp;
        ts_q       <= rd_q.t_start;
        diff_q     <= diff_c;
        off_q      <= off_full[DUR_W-1:0];
        dadj_q     <= dadj_c;
      end
    end
    if (cmd_i.mul) begin
      na_q   <= DIV_W'(absd) * DIV_W'(off_q);
      nb_q   <= DIV_W'(off_q) * DIV_W'(7'd100);
      days_q <= days_prod[DAY_SHIFT +: DAYS_W];
      neg_q  <= diff_q[TEMP_W];
      ra_q   <= '0;
      rb_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (ta >= {1'b0, dadj_q}) begin
        ra_q <= DUR_W'(ta - {1'b0, dadj_q});
        na_q <= {na_q[DIV_W-2:0], 1'b1};
      end else begin
        ra_q <= ta[DUR_W-1:0];
        na_q <= {na_q[DIV_W-2:0], 1'b0};
      end
      if (tb >= {1'b0, dadj_q}) begin
        rb_q <= DUR_W'(tb - {1'b0, dadj_q});
        nb_q <= {nb_q[DIV_W-2:0], 1'b1};
      end else begin
        rb_q <= tb[DUR_W-1:0];
        nb_q <= {nb_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    q_s      = neg_q ? -$signed({1'b0, na_q[TEMP_W-1:0]}) : $signed({1'b0, na_q[TEMP_W-1:0]});
    sp_sum   = (TEMP_W+2)'(ts_q) + (TEMP_W+2)'(q_s);
    drives   = active_q && (count_q != '0);
    rem_full = (e_q >= EL_W'(raw_q)) ? '0 : EL_W'(raw_q) - e_q;
    if (!go) begin
      sp_out   = dflt_q;
      idx_out  = '0;
      rem_out  = '1;
      prog_out = '0;
    end else begin
      if (!sp_found_q)     sp_out = last_te_q;
      else if (sp_ramp_q)  sp_out = sp_sum[TEMP_W-1:0];
      else                 sp_out = ts_q;
      idx_out  = IDX_OUT_W'(idx_q);
      rem_out  = (rem_full > EL_W'(REM_MAX)) ? REM_MAX : rem_full[REM_W-1:0];
      prog_out = (sp_found_q && sp_ramp_q) ? nb_q[6:0] : '0;
    end
    days_out = (active_q && tv_q) ? days_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= {acc_q, 5'(count_q), active_q, drives, prog_out, days_out,
                rem_out, idx_out, sp_out};
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/core/rsp_ctrl.sv =====
// Controller: sequences capture, step walk, multiply, divide and result hand-off.
// Depends on rsp_pkg; drives rsp_datapath.
module rsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rsp_pkg::rsp_sts_t sts_i,
  output rsp_pkg::rsp_cmd_t cmd_o
);
  import rsp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRIME = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [DIVC_W-1:0] cnt_q, cnt_d;
  logic              ov_q, ov_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d = sts_i.walk_go ? ST_WALK : ST_MUL;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_last) state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + DIVC_W'(1);
        if (cnt_q == DIV_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (cmd_o.load_out)   ov_d = 1'b1;
    else if (out_ready_i) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// ===== rtl/core/ramp_soak_setpoint_profile_core.sv =====
// Ramp/soak setpoint profile core: each transaction updates the step table or
// profile state and returns one result. When the profile drives the setpoint
// with a valid time, the loaded steps are walked one per cycle through the
// table read port, followed by a multiply step (elapsed days by reciprocal
// multiply) and a bit-serial divide for the ramp interpolation and progress.
// A new transaction is accepted only after the previous one has been through
// the walk, multiply and divide. A finished result waits in an output
// register while the next transaction is taken; a result that is still waiting
// when the following one finishes holds the core until it is taken. Depends on
// rsp_pkg, rsp_ctrl and rsp_datapath.
module ramp_soak_setpoint_profile_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // default_setpoint
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // step_is_ramp, temp_start, temp_end, duration_s, elapsed_s, time_valid, pad
  input  logic [95:0] s_axis_tdata_i,
  input  logic [2:0]  s_axis_tuser_i, // cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // setpoint, step_index, remaining_s, elapsed_days, progress_percent,
  // drives_setpoint, profile_on, steps_loaded, accepted
  output logic [79:0] m_axis_tdata_o
);
  import rsp_pkg::*;

  rsp_cmd_t cmd;
  rsp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rsp_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_cmd_i   (s_axis_tuser_i),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

// ===== rtl/core/rsp_checker.sv =====
// Port-level checker for the setpoint profile core, bound to the top level.
// Depends on ramp_soak_setpoint_profile_core_assert.svh.
`include "ramp_soak_setpoint_profile_core_assert.svh"

module rsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o
);

  `RSP_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `RSP_ASSERT(a_progress_max, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tdata_o[71:65] <= 7'd100)
  `RSP_ASSERT(a_drives_on, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[72] |-> m_axis_tdata_o[73] && m_axis_tdata_o[78:74] != 5'd0)
  `RSP_ASSERT(a_idle_unknown, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tdata_o[72] |-> m_axis_tdata_o[19:16] == 4'd0 && m_axis_tdata_o[48:20] == '1 && m_axis_tdata_o[71:65] == 7'd0)
  `RSP_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind ramp_soak_setpoint_profile_core rsp_checker u_rsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of ramp_soak_setpoint_profile_core: streams commands and queries,
// predicts every result in a scoreboard class and compares it field by field.
// Depends on rsp_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rsp_pkg::*;

  typedef struct {
    logic [2:0]         cmd;
    logic               ramp;
    logic signed [15:0] t_start;
    logic signed [15:0] t_end;
    logic [23:0]        dur;
    logic [31:0]        elapsed;
    logic               tv;
  } prof_item_t;

  typedef struct {
    logic signed [15:0] setpoint;
    logic [3:0]         index;
    logic signed [28:0] remaining;
    logic [15:0]        days;
    logic [6:0]         progress;
    logic               drives;
    logic               on;
    logic [4:0]         loaded;
    logic               accepted;
  } prof_res_t;

  class profile_scoreboard;
    step_t              steps[MAX_STEPS];
    int                 count;
    bit                 active;
    logic signed [15:0] dflt;
    prof_res_t          expected_q[$];
    int                 errors;

    function new();
      count = 0;
      active = 0;
      dflt = 16'sd2000;
      errors = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    function void note_item(prof_item_t it);
      prof_res_t r;
      longint raw_t, adj_t, dadj, off, rem, el;
      bit idx_found, sp_found;
      el = longint'(it.elapsed);
      r.accepted = 1'b1;
      case (it.cmd)
        CMD_APPEND: begin
          if (count >= MAX_STEPS) r.accepted = 1'b0;
          else begin
            steps[count[IDX_W-1:0]] = '{it.ramp, it.t_start, it.t_end, it.dur};
            count++;
          end
        end
        CMD_CLEAR: count = 0;
        CMD_START: active = 1;
        CMD_STOP: active = 0;
        default: ;
      endcase
      r.setpoint = dflt;
      r.index = '0;
      r.remaining = '1;
      r.days = '0;
      r.progress = '0;
      r.drives = active && count > 0;
      r.on = active;
      r.loaded = 5'(count);
      if (active && it.tv) r.days = 16'(el / 86400);
      if (r.drives && it.tv) begin
        raw_t = 0;
        adj_t = 0;
        idx_found = 0;
        sp_found = 0;
        r.index = 4'(count - 1);
        r.setpoint = steps[4'(count - 1)].t_end;
        for (int i = 0; i < count; i++) begin
          dadj = (steps[i[IDX_W-1:0]].dur == '0) ? 1 : longint'(steps[i[IDX_W-1:0]].dur);
          raw_t += longint'(steps[i[IDX_W-1:0]].dur);
          adj_t += dadj;
          if (!idx_found && el < raw_t) begin
            r.index = 4'(i);
            idx_found = 1;
          end
          if (!sp_found && el < adj_t) begin
            sp_found = 1;
            if (!steps[i[IDX_W-1:0]].ramp) r.setpoint = steps[i[IDX_W-1:0]].t_start;
            else begin
              off = el - (adj_t - dadj);
              r.setpoint = 16'(longint'(steps[i[IDX_W-1:0]].t_start) +
                (longint'(steps[i[IDX_W-1:0]].t_end) -
                 longint'(steps[i[IDX_W-1:0]].t_start)) * off / dadj);
              r.progress = 7'(off * 100 / dadj);
            end
          end
        end
        rem = (el >= raw_t) ? 0 : raw_t - el;
        if (rem > 268435455) rem = 268435455;
        r.remaining = 29'(rem);
      end
      expected_q.push_back(r);
    endfunction

    task check_result(logic [79:0] d);
      prof_res_t w;
      if (expected_q.size() == 0) begin
        $display("result with no pending transaction");
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (d[15:0] !== w.setpoint)
        report("setpoint", longint'($signed(d[15:0])), longint'(w.setpoint));
      if (d[19:16] !== w.index) report("step_index", longint'(d[19:16]), longint'(w.index));
      if (d[48:20] !== w.remaining)
        report("remaining_s", longint'($signed(d[48:20])), longint'(w.remaining));
      if (d[64:49] !== w.days) report("elapsed_days", longint'(d[64:49]), longint'(w.days));
      if (d[71:65] !== w.progress) report("progress", longint'(d[71:65]), longint'(w.progress));
      if (d[72] !== w.drives) report("drives_setpoint", longint'(d[72]), longint'(w.drives));
      if (d[73] !== w.on) report("profile_on", longint'(d[73]), longint'(w.on));
      if (d[78:74] !== w.loaded) report("steps_loaded", longint'(d[78:74]), longint'(w.loaded));
      if (d[79] !== w.accepted) report("accepted", longint'(d[79]), longint'(w.accepted));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [79:0] m_axis_tdata_o;

  profile_scoreboard sb = new();
  bit calm = 0;

  ramp_soak_setpoint_profile_core DUT (.*);

  initial forever #1 clk_i = ~clk_i;

  always @(negedge clk_i)
    m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 10);

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);

  task send(prof_item_t it);
    if (!calm && $urandom_range(0, 99) < 10) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end else @(negedge clk_i);
    s_axis_tvalid_i = 1;
    s_axis_tuser_i = it.cmd;
    s_axis_tdata_i = {6'b0, it.tv, it.elapsed, it.dur, it.t_end, it.t_start, it.ramp};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task cmd_item(logic [2:0] c, logic [31:0] el, logic tv);
    prof_item_t it;
    it.cmd = c;
    it.ramp = 1'($urandom);
    it.t_start = 16'($urandom);
    it.t_end = 16'($urandom);
    it.dur = 24'($urandom);
    it.elapsed = el;
    it.tv = tv;
    send(it);
  endtask

  task append_step(logic ramp, logic signed [15:0] ts, logic signed [15:0] te,
                   logic [23:0] dur);
    prof_item_t it;
    it.cmd = CMD_APPEND;
    it.ramp = ramp;
    it.t_start = ts;
    it.t_end = te;
    it.dur = dur;
    it.elapsed = $urandom;
    it.tv = 1'($urandom);
    send(it);
  endtask

  task drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (70) @(negedge clk_i);
  endtask

  task write_default(logic signed [15:0] v);
    drain();
    cfg_valid_i = 1;
    cfg_data_i = v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.dflt = v;
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task random_profile();
    int n, total;
    logic [23:0] d;
    cmd_item(CMD_CLEAR, $urandom, 1'($urandom));
    n = $urandom_range(1, 16);
    total = 0;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: d = '0;
        1: d = 24'($urandom);
        default: d = 24'($urandom_range(1, 40));
      endcase
      total += int'(d);
      append_step(1'($urandom), 16'($urandom), 16'($urandom), d);
    end
    cmd_item(CMD_START, 32'd0, 1'b1);
    repeat ($urandom_range(3, 10)) begin
      case ($urandom_range(0, 9))
        0: cmd_item(CMD_QUERY, $urandom, 1'($urandom));
        1: cmd_item(CMD_QUERY, $urandom_range(0, total + 5), 1'b0);
        2: cmd_item(3'($urandom_range(0, 7)), $urandom_range(0, total + 5), 1'b1);
        default: cmd_item(CMD_QUERY, $urandom_range(0, total + 5), 1'b1);
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    calm = 1;
    cmd_item(CMD_QUERY, 32'd100, 1'b1);
    cmd_item(CMD_START, 32'd200000, 1'b1);
    cmd_item(CMD_QUERY, 32'hFFFF_FFFF, 1'b1);
    append_step(1'b0, 16'sh7FFF, 16'sh8000, 24'd0);
    append_step(1'b1, 16'sh8000, 16'sh7FFF, 24'd10);
    append_step(1'b1, 16'sh7FFF, 16'sh8000, 24'd0);
    append_step(1'b1, 16'sd100, -16'sd300, 24'hFF_FFFF);
    for (int i = 4; i < 16; i++) append_step(i[0], 16'(i * 10), 16'(-i * 7), 24'(i));
    append_step(1'b1, 16'sd5, 16'sd5, 24'd5);
    cmd_item(CMD_QUERY, 32'd0, 1'b1);
    cmd_item(CMD_QUERY, 32'd5, 1'b1);
    cmd_item(CMD_QUERY, 32'd10, 1'b1);
    cmd_item(CMD_QUERY, 32'd12, 1'b1);
    cmd_item(CMD_QUERY, 32'd5000, 1'b1);
    cmd_item(CMD_QUERY, 32'hFFFF_FFFF, 1'b1);
    cmd_item(CMD_QUERY, 32'd7, 1'b0);
    cmd_item(3'd5, 32'd7, 1'b1);
    cmd_item(3'd6, 32'd7, 1'b1);
    cmd_item(3'd7, 32'd7, 1'b1);
    cmd_item(CMD_STOP, 32'd7, 1'b1);
    write_default(16'sh7FFF);
    cmd_item(CMD_QUERY, 32'd9, 1'b1);
    write_default(16'sh8000);
    cmd_item(CMD_START, 32'd9, 1'b1);
    cmd_item(CMD_CLEAR, 32'd9, 1'b1);
    calm = 0;
    for (int p = 0; p < 22; p++) begin
      if (p % 8 == 7) write_default(16'($urandom));
      calm = (p >= 8 && p < 12);
      random_profile();
    end
    calm = 0;
    drain();
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end
endmodule
